// ===== src/kmhr_pkg.sv =====
// Shared types, widths, register indexes and reset values for the key
// matrix hold/repeat block. No dependencies.
package kmhr_pkg;

    // Fixed field widths
    localparam int ROW_W      = 3;
    localparam int COL_W      = 2;
    localparam int CNT_W      = 12;
    localparam int STEP_W     = 4;
    localparam int MASK_BITS  = 20;
    localparam int MTH_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int FLAT_W     = 8;

    // Default matrix size
    localparam int DEF_ROWS = 5;
    localparam int DEF_COLS = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_MASK  = 2'd2;

    // Register reset values
    localparam logic [CNT_W-1:0]     LONG_RESET = 12'd500;
    localparam logic [STEP_W-1:0]    STEP_RESET = 4'd5;
    localparam logic [MASK_BITS-1:0] MASK_RESET = 20'd4096;
    localparam logic [MTH_W-1:0]     MTH_RESET  = 9'd50;

    // x/10 as (x * DIV10_MUL) >> DIV10_SHIFT, exact for 12-bit x
    localparam logic [CNT_W-1:0] DIV10_MUL   = 12'd3277;
    localparam int               DIV10_SHIFT = 15;

    // Per-key state entry
    typedef struct packed {
        logic             flag;
        logic [CNT_W-1:0] cnt;
    } entry_t;

    // Register set seen by the update logic
    typedef struct packed {
        logic [CNT_W-1:0]  long_hold;
        logic [MTH_W-1:0]  mod_thresh;
        logic [STEP_W-1:0] step;
    } cfg_t;

    // Status flags of one result
    typedef struct packed {
        logic report;
        logic released;
        logic long_hold;
    } res_t;

endpackage

// ===== src/kmhr_state_mem.sv =====
// Per-key state memory: synchronous array with registered read,
// flip-flop valid bits for reset-to-zero, write-to-read forwarding.
// Depends on kmhr_pkg.
module kmhr_state_mem #(
    parameter int DEPTH = kmhr_pkg::DEF_ROWS * kmhr_pkg::DEF_COLS,
    parameter int IDX_W = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output kmhr_pkg::entry_t     rd_data,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  kmhr_pkg::entry_t     wr_data
);

    kmhr_pkg::entry_t mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    kmhr_pkg::entry_t rd_data_reg;

    // Storage array
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Valid bits: entry never written reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Registered read, forwarding a same-edge write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else if (valid_reg[rd_addr]) begin
                rd_data_reg <= mem[rd_addr];
            end else begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/kmhr_update.sv =====
// Next-state logic for one key: press, short hold, long hold, release.
// Depends on kmhr_pkg.
module kmhr_update (
    input  kmhr_pkg::entry_t cur,
    input  logic             pressed,
    input  logic             is_mod,
    input  kmhr_pkg::cfg_t   cfg,
    output kmhr_pkg::entry_t nxt,
    output kmhr_pkg::res_t   res
);

    logic [kmhr_pkg::CNT_W:0] inc;
    logic [kmhr_pkg::CNT_W:0] sum_raw;
    logic [kmhr_pkg::CNT_W:0] sum_wrap;
    logic [kmhr_pkg::CNT_W:0] long_ext;
    logic                     hold_hit;

    assign long_ext = {1'b0, cfg.long_hold};
    assign inc      = {1'b0, cur.cnt} + 13'd1;
    assign hold_hit = (is_mod && (inc >= {4'b0, cfg.mod_thresh})) || (inc >= long_ext);
    assign sum_raw  = {1'b0, cur.cnt} + {9'b0, cfg.step};
    assign sum_wrap = (sum_raw >= long_ext) ? (sum_raw - long_ext) : sum_raw;

    // Case selection
    always_comb begin
        nxt = cur;
        res = '0;
        if (!pressed) begin
            res.released = cur.flag || (cur.cnt != '0);
            nxt          = '0;
        end else if (cur.cnt == '0) begin
            // new press, or first tick after entering long hold
            res.report = 1'b1;
            nxt.cnt    = cur.flag ? {8'b0, cfg.step} : 12'd1;
        end else if (!cur.flag) begin
            // short hold: count toward threshold
            if (hold_hit) begin
                nxt.cnt  = '0;
                nxt.flag = 1'b1;
            end else begin
                nxt.cnt = inc[kmhr_pkg::CNT_W-1:0];
            end
        end else if (is_mod) begin
            // long-held modifier reports every tick
            nxt.cnt    = 12'd1;
            res.report = 1'b1;
        end else begin
            // long-held key: repeat counter wraps on modulus
            nxt.cnt = sum_wrap[kmhr_pkg::CNT_W-1:0];
        end
        res.long_hold = nxt.flag;
    end

endmodule

// ===== src/key_matrix_hold_repeat.sv =====
// Top level of the key matrix hold/repeat block: config registers,
// two-stage read-modify-write pipeline and output register.
// Depends on kmhr_pkg, kmhr_state_mem, kmhr_update.
//
// Usage:
//   Input channel s_*: one sampled key per transfer (row, column, level).
//   Result channel m_*: exactly one result per input transfer, in order,
//   carrying the key position, report/release flags and long-hold flag.
//   Config channel cfg_*: always ready; index 0 long_hold_ticks,
//   1 repeat_step, 2 modifier_mask, other indexes ignored. Write only
//   while the block is idle.
// Path: an input transfer loads the stage 1 registers and the state read;
//   the result register loads when stage 1 advances and holds until taken.
// Throughput: one key per cycle while results are taken; per-key state
//   memory is read at the input transfer and written back as the key
//   moves to the result register; a same-key read then gets the write.
// Reset: all keys idle (counter zero, flag clear), registers at defaults.
// Stall: when the result register is full and m_ready is low, stage 1
//   still takes one key; once it is full too, s_ready drops. A taken
//   result frees the pipeline in the same cycle.
module key_matrix_hold_repeat #(
    parameter int ROWS = kmhr_pkg::DEF_ROWS,
    parameter int COLS = kmhr_pkg::DEF_COLS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [kmhr_pkg::ROW_W-1:0]       s_key_row,
    input  logic [kmhr_pkg::COL_W-1:0]       s_key_col,
    input  logic                             s_pressed,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [kmhr_pkg::ROW_W-1:0]       m_out_row,
    output logic [kmhr_pkg::COL_W-1:0]       m_out_col,
    output logic                             m_report_key,
    output logic                             m_released,
    output logic                             m_in_long_hold,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [kmhr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kmhr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int NKEYS     = ROWS * COLS;
    localparam int KEY_IDX_W = (NKEYS > 1) ? $clog2(NKEYS) : 1;
    localparam logic [4:0] ROWS_L = 5'(ROWS);
    localparam logic [4:0] COLS_L = 5'(COLS);

    // Configuration registers
    logic [kmhr_pkg::CNT_W-1:0]     long_hold_reg;
    logic [kmhr_pkg::STEP_W-1:0]    step_reg;
    logic [kmhr_pkg::MASK_BITS-1:0] mask_reg;
    logic [kmhr_pkg::MTH_W-1:0]     mod_thresh_reg;
    logic [2*kmhr_pkg::CNT_W-1:0]   div_prod;
    logic                           cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign div_prod  = {12'b0, cfg_data[kmhr_pkg::CNT_W-1:0]} * {12'b0, kmhr_pkg::DIV10_MUL};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_hold_reg  <= kmhr_pkg::LONG_RESET;
            step_reg       <= kmhr_pkg::STEP_RESET;
            mask_reg       <= kmhr_pkg::MASK_RESET;
            mod_thresh_reg <= kmhr_pkg::MTH_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                kmhr_pkg::REG_LONG_HOLD: begin
                    long_hold_reg  <= cfg_data[kmhr_pkg::CNT_W-1:0];
                    mod_thresh_reg <= div_prod[kmhr_pkg::DIV10_SHIFT +: kmhr_pkg::MTH_W];
                end
                kmhr_pkg::REG_REPEAT: begin
                    step_reg <= cfg_data[kmhr_pkg::STEP_W-1:0];
                end
                kmhr_pkg::REG_MOD_MASK: begin
                    mask_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Stage 0: decode key position
    logic                        s_xfer;
    logic                        in_matrix;
    logic [kmhr_pkg::FLAT_W-1:0] flat_idx;
    logic                        key_is_mod;

    assign in_matrix  = ({2'b0, s_key_row} < ROWS_L) && ({3'b0, s_key_col} < COLS_L);
    assign flat_idx   = 8'(s_key_row) * 8'(COLS) + 8'(s_key_col);
    assign key_is_mod = (flat_idx < 8'(kmhr_pkg::MASK_BITS))
                        && mask_reg[flat_idx[4:0]];

    // Stage 1 registers
    logic                          s1_valid_reg, s1_valid_next;
    logic [kmhr_pkg::ROW_W-1:0]    s1_row_reg;
    logic [kmhr_pkg::COL_W-1:0]    s1_col_reg;
    logic                          s1_pressed_reg;
    logic                          s1_in_mat_reg;
    logic                          s1_mod_reg;
    logic [KEY_IDX_W-1:0]          s1_idx_reg;
    logic                          s1_adv;

    // Output registers
    logic                          m_valid_reg, m_valid_next;
    logic [kmhr_pkg::ROW_W-1:0]    m_row_reg;
    logic [kmhr_pkg::COL_W-1:0]    m_col_reg;
    kmhr_pkg::res_t                m_res_reg;

    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign s_xfer  = s_valid && s_ready;

    // State memory and update
    kmhr_pkg::entry_t cur_entry;
    kmhr_pkg::entry_t nxt_entry;
    kmhr_pkg::res_t   upd_res;
    kmhr_pkg::cfg_t   cfg_bus;
    logic             mem_we;

    assign cfg_bus.long_hold  = long_hold_reg;
    assign cfg_bus.mod_thresh = mod_thresh_reg;
    assign cfg_bus.step       = step_reg;
    assign mem_we             = s1_adv && s1_in_mat_reg;

    kmhr_state_mem #(
        .DEPTH (NKEYS),
        .IDX_W (KEY_IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_xfer && in_matrix),
        .rd_addr (flat_idx[KEY_IDX_W-1:0]),
        .rd_data (cur_entry),
        .wr_en   (mem_we),
        .wr_addr (s1_idx_reg),
        .wr_data (nxt_entry)
    );

    kmhr_update u_upd (
        .cur     (cur_entry),
        .pressed (s1_pressed_reg),
        .is_mod  (s1_mod_reg),
        .cfg     (cfg_bus),
        .nxt     (nxt_entry),
        .res     (upd_res)
    );

    // Pipeline control
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_xfer) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Stage 1 payload capture
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_row_reg     <= s_key_row;
            s1_col_reg     <= s_key_col;
            s1_pressed_reg <= s_pressed;
            s1_in_mat_reg  <= in_matrix;
            s1_mod_reg     <= key_is_mod;
            s1_idx_reg     <= flat_idx[KEY_IDX_W-1:0];
        end
    end

    // Output payload capture; keys outside the matrix report nothing
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_row_reg <= s1_row_reg;
            m_col_reg <= s1_col_reg;
            m_res_reg <= s1_in_mat_reg ? upd_res : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_row      = m_row_reg;
    assign m_out_col      = m_col_reg;
    assign m_report_key   = m_res_reg.report;
    assign m_released     = m_res_reg.released;
    assign m_in_long_hold = m_res_reg.long_hold;

    // Assertions
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    a_adv_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv |=> m_valid_reg)
        else $error("advanced item did not reach the result register");

    a_release_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_released) |-> (!m_report_key && !m_in_long_hold))
        else $error("release result carries report or long-hold");

    a_outside_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (({2'b0, m_out_row} >= ROWS_L) || ({3'b0, m_out_col} >= COLS_L)))
        |-> (!m_report_key && !m_released && !m_in_long_hold))
        else $error("key outside the matrix produced flags");

    a_mod_thresh: assert property (@(posedge aclk) disable iff (!aresetn)
        {3'b0, mod_thresh_reg} <= long_hold_reg)
        else $error("modifier threshold above long-hold threshold");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for key_matrix_hold_repeat: directed key sequences, then random
// hold/release bursts under four register settings and idling mixes. Depends on kmhr_pkg.
module tb_top;

    localparam int KEY_ROWS  = kmhr_pkg::DEF_ROWS;
    localparam int KEY_COLS  = kmhr_pkg::DEF_COLS;
    localparam int NUM_KEYS  = KEY_ROWS * KEY_COLS;
    localparam int CYCLE_CAP = 200000;
    localparam int PRINT_CAP = 40;

    // index 3 decodes to no register
    localparam logic [kmhr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [kmhr_pkg::ROW_W-1:0] row;
        logic [kmhr_pkg::COL_W-1:0] col;
        logic                       pressed;
    } key_sample_t;

    typedef struct packed {
        logic [kmhr_pkg::ROW_W-1:0] row;
        logic [kmhr_pkg::COL_W-1:0] col;
        kmhr_pkg::res_t             flags;
    } key_report_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    logic [kmhr_pkg::ROW_W-1:0]      s_key_row = '0;
    logic [kmhr_pkg::COL_W-1:0]      s_key_col = '0;
    logic                            s_pressed = 1'b0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    logic [kmhr_pkg::ROW_W-1:0]      m_out_row;
    logic [kmhr_pkg::COL_W-1:0]      m_out_col;
    logic                            m_report_key;
    logic                            m_released;
    logic                            m_in_long_hold;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [kmhr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [kmhr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // register copy and per-key state of the predictor
    logic [kmhr_pkg::CNT_W-1:0]     hold_limit;
    logic [kmhr_pkg::STEP_W-1:0]    repeat_inc;
    logic [kmhr_pkg::MASK_BITS-1:0] modifier_bits;
    logic [kmhr_pkg::CNT_W-1:0]     key_ticks [NUM_KEYS];
    logic                           key_long  [NUM_KEYS];

    key_sample_t scan_queue[$];
    key_report_t pending_reports[$];
    key_sample_t drive_smp;
    key_report_t want;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        s_accepted     = 1'b0;
    int unsigned cycle_count    = 0;
    int unsigned errors         = 0;
    int unsigned results_seen   = 0;
    int unsigned report_count   = 0;
    int unsigned release_count  = 0;
    int unsigned long_count     = 0;
    int unsigned setting_count  = 1;

    key_matrix_hold_repeat uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_key_row      (s_key_row),
        .s_key_col      (s_key_col),
        .s_pressed      (s_pressed),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_row      (m_out_row),
        .m_out_col      (m_out_col),
        .m_report_key   (m_report_key),
        .m_released     (m_released),
        .m_in_long_hold (m_in_long_hold),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Next hold/repeat state of one key and the result it produces
    function automatic key_report_t advance_key(input key_sample_t smp);
        key_report_t res;
        int unsigned idx;
        logic [kmhr_pkg::CNT_W:0] nxt;
        logic flg;
        logic is_mod;
        res.row   = smp.row;
        res.col   = smp.col;
        res.flags = '0;
        if (smp.row < KEY_ROWS && smp.col < KEY_COLS) begin
            idx    = smp.row * KEY_COLS + smp.col;
            nxt    = {1'b0, key_ticks[idx]};
            flg    = key_long[idx];
            is_mod = (idx < kmhr_pkg::MASK_BITS) && modifier_bits[idx];
            if (!smp.pressed) begin
                res.flags.released = (nxt != '0) || flg;
                nxt = '0;
                flg = 1'b0;
            end else if (nxt == '0) begin
                // fresh press, or first tick after entering long-hold
                res.flags.report = 1'b1;
                if (flg) nxt = {9'b0, repeat_inc};
                else nxt = 13'd1;
            end else if (!flg) begin
                nxt = nxt + 13'd1;
                if ((is_mod && nxt >= {1'b0, hold_limit / 12'd10})
                    || nxt >= {1'b0, hold_limit}) begin
                    nxt = '0;
                    flg = 1'b1;
                end
            end else if (is_mod) begin
                nxt = 13'd1;
                res.flags.report = 1'b1;
            end else begin
                // one conditional subtract stands in for the modulo
                nxt = nxt + {9'b0, repeat_inc};
                if (nxt >= {1'b0, hold_limit}) nxt = nxt - {1'b0, hold_limit};
            end
            key_ticks[idx]      = nxt[kmhr_pkg::CNT_W-1:0];
            key_long[idx]       = flg;
            res.flags.long_hold = flg;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned exp_val,
                                   input int unsigned got_val);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_count, what, exp_val, got_val);
    endtask

    task automatic add_key(input int unsigned row, input int unsigned col,
                           input logic pressed);
        key_sample_t smp;
        smp.row     = row[kmhr_pkg::ROW_W-1:0];
        smp.col     = col[kmhr_pkg::COL_W-1:0];
        smp.pressed = pressed;
        scan_queue.push_back(smp);
    endtask

    // One register write; cfg_valid is left high for a following write
    task automatic write_reg(input logic [kmhr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [kmhr_pkg::CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_regs(input logic [kmhr_pkg::CNT_W-1:0] limit,
                            input logic [kmhr_pkg::STEP_W-1:0] step,
                            input logic [kmhr_pkg::MASK_BITS-1:0] mask);
        write_reg(kmhr_pkg::REG_LONG_HOLD, {8'b0, limit});
        write_reg(kmhr_pkg::REG_REPEAT, {16'b0, step});
        write_reg(kmhr_pkg::REG_MOD_MASK, mask);
        write_reg(REG_UNUSED, 20'($urandom));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        setting_count++;
    endtask

    // Wait until every queued key has been taken and every result has come back
    task automatic drain;
        do @(posedge aclk); while (scan_queue.size() != 0 || s_valid);
        do @(negedge aclk); while (pending_reports.size() != 0);
    endtask

    // Hold bursts on random keys, with stray samples mixed in
    task automatic fill_random(input int unsigned budget);
        int unsigned n;
        int unsigned burst_cap;
        int unsigned hold_len;
        int unsigned row;
        int unsigned col;
        int unsigned nrow;
        n = 0;
        while (n < budget) begin
            row       = $urandom_range(0, KEY_ROWS - 1);
            col       = $urandom_range(0, KEY_COLS - 1);
            burst_cap = (hold_limit > 60) ? 120 : 3 * hold_limit + 4;
            hold_len  = $urandom_range(1, burst_cap);
            for (int unsigned i = 0; i < hold_len; i++) begin
                if ($urandom_range(0, 99) < 12) begin
                    nrow = $urandom_range(0, 7);
                    add_key(nrow, $urandom_range(0, 3), 1'($urandom_range(0, 1)));
                    if (nrow < KEY_ROWS) n++;
                end
                add_key(row, col, 1'b1);
                n++;
            end
            // some keys stay held into the next register setting
            if ($urandom_range(0, 99) < 85) begin
                add_key(row, col, 1'b0);
                n++;
            end
        end
    endtask

    // Driver: input transfers and result back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (!s_valid || s_accepted) begin
                if (scan_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    drive_smp = scan_queue.pop_front();
                    s_valid   <= 1'b1;
                    s_key_row <= drive_smp.row;
                    s_key_col <= drive_smp.col;
                    s_pressed <= drive_smp.pressed;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: register copy, prediction on input transfer, check on result transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_limit    = kmhr_pkg::LONG_RESET;
            repeat_inc    = kmhr_pkg::STEP_RESET;
            modifier_bits = kmhr_pkg::MASK_RESET;
            key_ticks     = '{default: '0};
            key_long      = '{default: 1'b0};
            s_accepted    = 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    kmhr_pkg::REG_LONG_HOLD: hold_limit    = cfg_data[kmhr_pkg::CNT_W-1:0];
                    kmhr_pkg::REG_REPEAT:    repeat_inc    = cfg_data[kmhr_pkg::STEP_W-1:0];
                    kmhr_pkg::REG_MOD_MASK:  modifier_bits = cfg_data[kmhr_pkg::MASK_BITS-1:0];
                    default: ;
                endcase
            end
            s_accepted = s_valid && s_ready;
            if (s_accepted)
                pending_reports.push_back(advance_key({s_key_row, s_key_col, s_pressed}));
            if (m_valid && m_ready) begin
                if (pending_reports.size() == 0) begin
                    report_mismatch("result with nothing pending, row", 0, m_out_row);
                end else begin
                    want = pending_reports.pop_front();
                    results_seen++;
                    if (want.flags.report) report_count++;
                    if (want.flags.released) release_count++;
                    if (want.flags.long_hold) long_count++;
                    if (m_out_row !== want.row)
                        report_mismatch("out_row", want.row, m_out_row);
                    if (m_out_col !== want.col)
                        report_mismatch("out_col", want.col, m_out_col);
                    if (m_report_key !== want.flags.report)
                        report_mismatch("report_key", want.flags.report, m_report_key);
                    if (m_released !== want.flags.released)
                        report_mismatch("released", want.flags.released, m_released);
                    if (m_in_long_hold !== want.flags.long_hold)
                        report_mismatch("in_long_hold", want.flags.long_hold, m_in_long_hold);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_reports.size());
            $display("FAIL key_matrix_hold_repeat");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed, reset registers: press, hold, release, modifier key, off-matrix keys
        @(posedge aclk);
        add_key(0, 0, 1'b1);
        add_key(0, 0, 1'b1);
        add_key(0, 0, 1'b0);
        add_key(0, 0, 1'b0);
        add_key(4, 3, 1'b1);
        add_key(4, 3, 1'b0);
        add_key(3, 0, 1'b1);
        add_key(3, 0, 1'b1);
        add_key(7, 3, 1'b1);
        add_key(5, 0, 1'b0);
        add_key(6, 2, 1'b1);
        drain();

        // Tiny threshold: modifier goes long on its first hold tick, then repeats
        set_regs(12'd9, 4'd15, 20'h00002);
        @(posedge aclk);
        add_key(0, 1, 1'b1);
        add_key(0, 1, 1'b1);
        add_key(0, 1, 1'b1);
        add_key(0, 1, 1'b1);
        add_key(0, 1, 1'b0);
        drain();

        // Zero threshold: an ordinary key goes long at once and keeps adding the step
        set_regs(12'd0, 4'd15, 20'h00002);
        @(posedge aclk);
        add_key(1, 1, 1'b1);
        add_key(1, 1, 1'b1);
        add_key(1, 1, 1'b1);
        add_key(1, 1, 1'b1);
        add_key(1, 1, 1'b1);
        add_key(1, 1, 1'b0);
        drain();

        // Random bursts, one register setting and idling mix per phase
        set_regs(12'd16, 4'd1, 20'($urandom));
        @(posedge aclk);
        fill_random(90);
        drain();

        set_regs(12'd40, 4'd15, 20'h00000);
        @(posedge aclk);
        send_idle_pct  = 78;
        recv_stall_pct = 0;
        fill_random(90);
        drain();

        // held counters now sit far above the new modulus
        set_regs(12'd16, 4'd15, 20'hFFFFF);
        @(posedge aclk);
        send_idle_pct  = 0;
        recv_stall_pct = 78;
        fill_random(90);
        drain();

        set_regs(12'd4095, 4'($urandom_range(1, 15)), 20'($urandom));
        @(posedge aclk);
        send_idle_pct  = 27;
        recv_stall_pct = 27;
        fill_random(90);
        drain();

        repeat (8) @(posedge aclk);
        $display("checked %0d results over %0d register settings", results_seen, setting_count);
        $display("  %0d key reports, %0d releases, %0d results in long-hold",
                 report_count, release_count, long_count);
        if (errors == 0) begin
            $display("PASS key_matrix_hold_repeat");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL key_matrix_hold_repeat");
        end
        $finish;
    end

endmodule
